// ===== sv/ptfa_pkg.sv =====
package ptfa_pkg;
    localparam int NUM_SLOTS_DEF    = 4;
    localparam int HEADER_BYTES_DEF = 256;
    localparam int NAME_W   = 120;
    localparam int ADDR_W   = 31;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOSPACE   = 3'd3,
        ST_NOTFOUND  = 3'd4
    } t_status;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_DEL = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_RSVD  = 2'd3;

    typedef struct packed {
        logic load;
        logic sort_step;
        logic scan_step;
        logic scan_end;
        logic commit_add;
        logic commit_del;
    } t_cmd;

    typedef struct packed {
        logic is_del;
        logic full;
        logic dup;
        logic found;
        logic sort_done;
        logic scan_done;
        logic have_gap;
    } t_sts;

    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] r;
        logic ended;
        r = n;
        ended = 1'b0;
        for (int i = 0; i < 15; i++) begin
            if (ended) r[i*8 +: 8] = 8'd0;
            else if (n[i*8 +: 8] == 8'd0) ended = 1'b1;
        end
        return r;
    endfunction
endpackage

// ===== sv/ptfa_ctrl.sv =====
module ptfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ptfa_pkg::t_sts  i_sts,
    output ptfa_pkg::t_cmd  o_cmd
);
    import ptfa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SORT, S_SCAN, S_DONE} t_state;
    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_del) begin
                    o_cmd.commit_del = i_sts.found;
                    n_state = S_DONE;
                end else if (i_sts.full || i_sts.dup) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (i_sts.sort_done) n_state = S_SCAN;
                else o_cmd.sort_step = 1'b1;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_end = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.commit_add = !i_sts.is_del && i_sts.have_gap;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_cmd.load) else $error("back-to-back load");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit_add && o_cmd.commit_del)) else $error("double commit");
endmodule

// ===== sv/ptfa_dp.sv =====
module ptfa_dp #(
    parameter int NUM_SLOTS    = ptfa_pkg::NUM_SLOTS_DEF,
    parameter int HEADER_BYTES = ptfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptfa_pkg::t_cmd                 i_cmd,
    output ptfa_pkg::t_sts                 o_sts,
    input  logic [ptfa_pkg::ADDR_W-1:0]    i_disk_size,
    input  logic                           i_req_type,
    input  logic [63:0]                    i_name_lo,
    input  logic [55:0]                    i_name_hi,
    input  logic [ptfa_pkg::ADDR_W-1:0]    i_req_size,
    input  logic                           i_part_kind,
    input  logic [1:0]                     i_fit_mode,
    output logic [2:0]                     o_status,
    output logic [1:0]                     o_slot_index,
    output logic [ptfa_pkg::ADDR_W-1:0]    o_start_offset
);
    import ptfa_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 2);
    localparam int EW = ADDR_W + 1;

    logic              r_valid [NUM_SLOTS];
    logic [ADDR_W-1:0] r_start [NUM_SLOTS];
    logic [ADDR_W-1:0] r_size  [NUM_SLOTS];
    logic [NAME_W-1:0] r_name  [NUM_SLOTS];
    logic              r_kind  [NUM_SLOTS];
    logic [1:0]        r_fit   [NUM_SLOTS];

    logic              r_req;
    logic [NAME_W-1:0] r_nm;
    logic [ADDR_W-1:0] r_need;
    logic              r_pkind;
    logic [1:0]        r_mode;
    logic [SW-1:0]     r_free, r_hit;
    logic              r_full, r_found;

    logic              r_sv [NUM_SLOTS];
    logic [EW-1:0]     r_ss [NUM_SLOTS];
    logic [EW-1:0]     r_se [NUM_SLOTS];
    logic [CW-1:0]     r_pass, r_idx;
    logic [EW-1:0]     r_cursor;
    logic              r_have;
    logic [ADDR_W-1:0] r_cstart;
    logic [EW-1:0]     r_csize;
    logic [2:0]        r_status;
    logic [1:0]        r_slot_o;
    logic [ADDR_W-1:0] r_start_o;

    logic [NAME_W-1:0] w_nm;
    logic [SW-1:0]     w_free, w_hit;
    logic              w_full, w_found;
    assign w_nm = trim_name({i_name_hi, i_name_lo});

    always_comb begin
        w_free = '0;
        w_full = 1'b1;
        w_hit = '0;
        w_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = SW'(i);
                w_full = 1'b0;
            end
            if (r_valid[i] && r_name[i] == w_nm) begin
                w_hit = SW'(i);
                w_found = 1'b1;
            end
        end
    end

    logic          w_gap;
    logic [EW-1:0] w_gs, w_gz;
    logic          w_last;
    logic [SW-1:0] w_ix;
    assign w_last = (r_idx == CW'(NUM_SLOTS));
    assign w_ix   = r_idx[SW-1:0];
    always_comb begin
        w_gs = r_cursor;
        w_gap = 1'b0;
        w_gz = '0;
        if (w_last) begin
            if (r_cursor < {1'b0, i_disk_size}) begin
                w_gap = 1'b1;
                w_gz = {1'b0, i_disk_size} - r_cursor;
            end
        end else if (r_sv[w_ix] && r_ss[w_ix] > r_cursor) begin
            w_gap = 1'b1;
            w_gz = r_ss[w_ix] - r_cursor;
        end
    end

    logic w_take;
    always_comb begin
        w_take = 1'b0;
        if (w_gap && w_gz >= {1'b0, r_need}) begin
            if (!r_have) w_take = 1'b1;
            else if (r_mode == FIT_BEST) w_take = w_gz < r_csize;
            else if (r_mode == FIT_WORST) w_take = w_gz > r_csize;
        end
    end

    assign o_sts.is_del    = r_req;
    assign o_sts.full      = r_full;
    assign o_sts.dup       = r_found;
    assign o_sts.found     = r_found;
    assign o_sts.sort_done = (r_pass == CW'(NUM_SLOTS));
    assign o_sts.scan_done = w_last;
    assign o_sts.have_gap  = r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) r_valid[i] <= 1'b0;
        end else begin
            if (i_cmd.commit_add) r_valid[r_free] <= 1'b1;
            if (i_cmd.commit_del) r_valid[r_hit]  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_nm    <= w_nm;
            r_need  <= i_req_size;
            r_pkind <= i_part_kind;
            r_mode  <= i_fit_mode;
            r_free  <= w_free;
            r_full  <= w_full;
            r_hit   <= w_hit;
            r_found <= w_found;
            r_pass  <= '0;
            r_idx   <= '0;
            r_cursor <= EW'(HEADER_BYTES);
            r_have  <= 1'b0;
            r_cstart <= '0;
            r_csize <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_sv[i] <= r_valid[i];
                r_ss[i] <= {1'b0, r_start[i]};
                r_se[i] <= {1'b0, r_start[i]} + {1'b0, r_size[i]};
            end
            if (i_req_type == REQ_DEL) begin
                r_status  <= w_found ? ST_OK : ST_NOTFOUND;
                r_slot_o  <= w_found ? 2'(w_hit) : 2'd0;
                r_start_o <= '0;
            end else begin
                r_status  <= w_full ? ST_FULL : (w_found ? ST_DUP : ST_NOSPACE);
                r_slot_o  <= '0;
                r_start_o <= '0;
            end
        end
        if (i_cmd.sort_step) begin
            r_pass <= r_pass + CW'(1);
            for (int i = 0; i + 1 < NUM_SLOTS; i++) begin
                if ((i % 2) == int'(r_pass[0])) begin
                    if ((!r_sv[i] && r_sv[i+1]) || (r_sv[i] && r_sv[i+1] &&
                        (r_ss[i] > r_ss[i+1] ||
                         (r_ss[i] == r_ss[i+1] && r_se[i] > r_se[i+1])))) begin
                        r_sv[i] <= r_sv[i+1]; r_sv[i+1] <= r_sv[i];
                        r_ss[i] <= r_ss[i+1]; r_ss[i+1] <= r_ss[i];
                        r_se[i] <= r_se[i+1]; r_se[i+1] <= r_se[i];
                    end
                end
            end
        end
        if (i_cmd.scan_step) begin
            if (w_take) begin
                r_have   <= 1'b1;
                r_cstart <= w_gs[ADDR_W-1:0];
                r_csize  <= w_gz;
            end
            if (!r_sv[w_ix] || (r_have && (r_mode == FIT_FIRST || r_mode == FIT_RSVD)))
                r_idx <= CW'(NUM_SLOTS);
            else begin
                r_idx <= r_idx + CW'(1);
                r_cursor <= r_se[w_ix];
            end
        end
        if (i_cmd.scan_end) begin
            if (w_take || r_have) begin
                r_status  <= ST_OK;
                r_slot_o  <= 2'(r_free);
                r_start_o <= w_take ? w_gs[ADDR_W-1:0] : r_cstart;
                r_have    <= 1'b1;
                if (w_take) r_cstart <= w_gs[ADDR_W-1:0];
            end
        end
        if (i_cmd.commit_add) begin
            r_start[r_free] <= r_cstart;
            r_size[r_free]  <= r_need;
            r_name[r_free]  <= r_nm;
            r_kind[r_free]  <= r_pkind;
            r_fit[r_free]   <= r_mode;
        end
        if (i_cmd.commit_del) begin
            r_start[r_hit] <= '0;
            r_size[r_hit]  <= '0;
            r_name[r_hit]  <= '0;
            r_kind[r_hit]  <= 1'b0;
            r_fit[r_hit]   <= '0;
        end
    end

    assign o_status       = r_status;
    assign o_slot_index   = r_slot_o;
    assign o_start_offset = r_start_o;

    logic w_unused;
    assign w_unused = ^{r_kind[0], r_fit[0]};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_add |-> !r_valid[r_free]) else $error("add over live slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_del |-> r_valid[r_hit]) else $error("delete of empty slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_add |-> r_status == ST_OK) else $error("add without ok");
endmodule

// ===== sv/partition_table_fit_allocator.sv =====
// Channel | Signals                                        | Direction
// in      | i_in_valid, o_in_stall, request fields         | into block
// out     | o_out_valid, i_out_stall, status/slot/start    | out of block
// cfg     | APB psel/penable/pwrite/paddr/pwdata/prdata    | register disk_size
// A delete or a refused add passes through S_CHECK then S_DONE before the result is valid;
// an add that searches also passes S_SORT then S_SCAN in between (sort then gap scan).
// The odd-even sort pass and one-gap-per-cycle scan set the add latency.
// Reset clears the slot valid bits and disk_size.
// Input stalls while a request is at work or a result is held under output stall.
module partition_table_fit_allocator #(
    parameter int NUM_SLOTS    = ptfa_pkg::NUM_SLOTS_DEF,
    parameter int HEADER_BYTES = ptfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [63:0]                 i_name_lo,
    input  logic [55:0]                 i_name_hi,
    input  logic [ptfa_pkg::ADDR_W-1:0] i_req_size,
    input  logic                        i_part_kind,
    input  logic [1:0]                  i_fit_mode,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [1:0]                  o_slot_index,
    output logic [ptfa_pkg::ADDR_W-1:0] o_start_offset
);
    import ptfa_pkg::*;

    logic [ADDR_W-1:0] r_disk_size;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {1'b0, r_disk_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_size <= '0;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_disk_size <= pwdata[ADDR_W-1:0];
        end
    end

    ptfa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    ptfa_dp #(.NUM_SLOTS(NUM_SLOTS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_disk_size(r_disk_size),
        .i_req_type(i_req_type), .i_name_lo(i_name_lo), .i_name_hi(i_name_hi),
        .i_req_size(i_req_size), .i_part_kind(i_part_kind), .i_fit_mode(i_fit_mode),
        .o_status(o_status), .o_slot_index(o_slot_index),
        .o_start_offset(o_start_offset)
    );
endmodule
